@@ rtl/hfc_pkg.sv @@
package hfc_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_HIGH_THRESHOLD  = 3'd0,
      CSR_LOW_THRESHOLD   = 3'd1,
      CSR_TARGET_EDGES    = 3'd2,
      CSR_TIMEOUT_SAMPLES = 3'd3,
      CSR_SAMPLE_RATE_HZ  = 3'd4
   } csr_index_type;

   // fixed field widths
   localparam int THRESH_BITS  = 16;
   localparam int TARGET_BITS  = 16;
   localparam int TIMEOUT_BITS = 24;
   localparam int RATE_BITS    = 24;
   localparam int FREQ_BITS    = 32;
   localparam int FRAC_BITS    = 8;
   localparam int EDGE_OUT_BITS  = 16;
   localparam int COUNT_OUT_BITS = 24;

   // register reset values
   localparam logic signed [THRESH_BITS-1:0] HIGH_THRESHOLD_RESET = 16'sd1638;
   localparam logic signed [THRESH_BITS-1:0] LOW_THRESHOLD_RESET  = -16'sd1638;
   localparam logic [TARGET_BITS-1:0]  TARGET_EDGES_RESET    = 16'd1024;
   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_SAMPLES_RESET = 24'd65536;
   localparam logic [RATE_BITS-1:0]    SAMPLE_RATE_HZ_RESET  = 24'd250000;

   // result status codes
   localparam logic STATUS_FREQUENCY = 1'b0;
   localparam logic STATUS_TIMEOUT   = 1'b1;

endpackage

@@ rtl/hfc_if.sv @@
// sample channel
interface hfc_req_if #(
   parameter int SAMPLE_BITS = 16
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// result channel
interface hfc_rsp_if import hfc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      status;
   logic [FREQ_BITS-1:0]      frequency_q8;
   logic [EDGE_OUT_BITS-1:0]  edge_total;
   logic [COUNT_OUT_BITS-1:0] sample_total;

   modport source (output valid, output status, output frequency_q8,
                   output edge_total, output sample_total, input ready);
   modport sink   (input valid, input status, input frequency_q8,
                   input edge_total, input sample_total, output ready);
endinterface

// configuration write channel
interface hfc_csr_if import hfc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/hysteresis_frequency_counter.sv @@
// channel | dir | payload                                          | transaction
// req     | in  | sample                                           | valid & ready
// rsp     | out | status, frequency_q8, edge_total, sample_total   | valid & ready
// csr     | in  | index, data                                      | valid & ready
//
// A timeout result is loaded on the same edge that takes its sample.
// A sample that reaches the edge target without timing out holds req.ready low while
// one multiply runs, then the restoring divider retires one quotient bit a cycle,
// then the result is loaded; with no counted samples only the load cycle remains.
// Reset is synchronous; it restores register defaults and returns to seeking.
// A waiting result holds req.ready low and delays the load cycle until it is taken.
module hysteresis_frequency_counter import hfc_pkg::*; #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 24,
   parameter int EDGE_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   hfc_req_if.sink     req,
   hfc_rsp_if.source   rsp,
   hfc_csr_if.sink     csr
);

   localparam int CMP_BITS     = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
   localparam int PROD_BITS    = RATE_BITS + EDGE_BITS;
   localparam int DIV_BITS     = PROD_BITS + FRAC_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
   localparam int WIDE_BITS    = 33;
   localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DIV_BITS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_EMIT
   } state_type;

   // configuration registers
   logic signed [THRESH_BITS-1:0] high_threshold_ff;
   logic signed [THRESH_BITS-1:0] low_threshold_ff;
   logic [TARGET_BITS-1:0]        target_edges_ff;
   logic [TIMEOUT_BITS-1:0]       timeout_samples_ff;
   logic [RATE_BITS-1:0]          sample_rate_hz_ff;

   // measurement state
   state_type             state_ff;
   logic                  measuring_ff, measuring_in;
   logic                  level_ff, level_in;
   logic                  started_ff, started_in;
   logic [EDGE_BITS-1:0]  edge_count_ff, edge_count_in;
   logic [COUNT_BITS-1:0] sample_count_ff, sample_count_in;

   // divider
   logic [DIV_BITS-1:0]     quo_ff;
   logic [COUNT_BITS-1:0]   rem_ff;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff;
   logic [COUNT_BITS:0]     trial;
   logic                    trial_ge;
   logic [COUNT_BITS:0]     trial_diff;
   logic [DIV_BITS-1:0]     quo_in;
   logic [PROD_BITS-1:0]    product;

   // result register
   logic                      rsp_valid_ff;
   logic                      rsp_status_ff;
   logic [FREQ_BITS-1:0]      rsp_freq_ff;
   logic [EDGE_OUT_BITS-1:0]  rsp_edge_ff;
   logic [COUNT_OUT_BITS-1:0] rsp_count_ff;

   logic signed [CMP_BITS-1:0] sample_ext, high_ext, low_ext;
   logic                       rsp_free, req_fire;
   logic                       step_timeout, step_target;
   logic [WIDE_BITS-1:0]       edge_wide, count_wide;
   logic [FREQ_BITS-1:0]       freq_sat;

   // handshakes
   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && rsp_free;
   assign req_fire  = req.valid && req.ready;
   assign csr.ready = 1'b1;

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.frequency_q8 = rsp_freq_ff;
   assign rsp.edge_total   = rsp_edge_ff;
   assign rsp.sample_total = rsp_count_ff;

   assign sample_ext = CMP_BITS'(req.sample);
   assign high_ext   = CMP_BITS'(high_threshold_ff);
   assign low_ext    = CMP_BITS'(low_threshold_ff);

   // one sample step of the hysteresis comparator and counters
   always_comb begin
      measuring_in    = measuring_ff;
      level_in        = level_ff;
      started_in      = started_ff;
      edge_count_in   = edge_count_ff;
      sample_count_in = sample_count_ff;
      step_timeout    = 1'b0;
      step_target     = 1'b0;
      if (!measuring_ff) begin
         if (sample_ext < low_ext) begin
            measuring_in    = 1'b1;
            level_in        = 1'b0;
            started_in      = 1'b0;
            edge_count_in   = '0;
            sample_count_in = '0;
         end
      end else begin
         if (sample_ext > high_ext) begin
            level_in   = 1'b1;
            started_in = 1'b1;
         end else if (sample_ext < low_ext) begin
            level_in = 1'b0;
         end
         if (level_in && !level_ff && !(&edge_count_ff)) begin
            edge_count_in = edge_count_ff + 1'b1;
         end
         if (started_in && !(&sample_count_ff)) begin
            sample_count_in = sample_count_ff + 1'b1;
         end
         step_timeout = started_in &&
                        (WIDE_BITS'(sample_count_in) > WIDE_BITS'(timeout_samples_ff));
         step_target  = WIDE_BITS'(edge_count_in) >= WIDE_BITS'(target_edges_ff);
         if (step_timeout || step_target) begin
            measuring_in = 1'b0;
         end
      end
   end

   // multiply and divide step
   assign product    = PROD_BITS'(sample_rate_hz_ff) * PROD_BITS'(edge_count_ff);
   assign trial      = {rem_ff, quo_ff[DIV_BITS-1]};
   assign trial_ge   = trial >= {1'b0, sample_count_ff};
   assign trial_diff = trial - {1'b0, sample_count_ff};

   always_comb begin
      quo_in = {quo_ff[DIV_BITS-2:0], trial_ge};
   end

   assign edge_wide  = WIDE_BITS'(edge_count_ff);
   assign count_wide = WIDE_BITS'(sample_count_ff);
   assign freq_sat   = (quo_ff[DIV_BITS-1:FREQ_BITS] != '0) ? '1 : quo_ff[FREQ_BITS-1:0];

   // sequencer, configuration and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         measuring_ff       <= 1'b0;
         level_ff           <= 1'b0;
         started_ff         <= 1'b0;
         edge_count_ff      <= '0;
         sample_count_ff    <= '0;
         rsp_valid_ff       <= 1'b0;
         div_cnt_ff         <= '0;
         high_threshold_ff  <= HIGH_THRESHOLD_RESET;
         low_threshold_ff   <= LOW_THRESHOLD_RESET;
         target_edges_ff    <= TARGET_EDGES_RESET;
         timeout_samples_ff <= TIMEOUT_SAMPLES_RESET;
         sample_rate_hz_ff  <= SAMPLE_RATE_HZ_RESET;
      end else begin
         // register writes
         if (csr.valid) begin
            case (csr.index)
               CSR_HIGH_THRESHOLD:  high_threshold_ff  <= csr.data[THRESH_BITS-1:0];
               CSR_LOW_THRESHOLD:   low_threshold_ff   <= csr.data[THRESH_BITS-1:0];
               CSR_TARGET_EDGES:    target_edges_ff    <= csr.data[TARGET_BITS-1:0];
               CSR_TIMEOUT_SAMPLES: timeout_samples_ff <= csr.data[TIMEOUT_BITS-1:0];
               CSR_SAMPLE_RATE_HZ:  sample_rate_hz_ff  <= csr.data[RATE_BITS-1:0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  measuring_ff    <= measuring_in;
                  level_ff        <= level_in;
                  started_ff      <= started_in;
                  edge_count_ff   <= edge_count_in;
                  sample_count_ff <= sample_count_in;
                  if (step_timeout) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= STATUS_TIMEOUT;
                     rsp_freq_ff   <= '0;
                     rsp_edge_ff   <= EDGE_OUT_BITS'(edge_count_in);
                     rsp_count_ff  <= COUNT_OUT_BITS'(sample_count_in);
                  end else if (step_target) begin
                     if (sample_count_in == '0) begin
                        quo_ff   <= '0;
                        state_ff <= ST_EMIT;
                     end else begin
                        state_ff <= ST_MUL;
                     end
                  end
               end
            end
            ST_MUL: begin
               quo_ff     <= {product, {FRAC_BITS{1'b0}}};
               rem_ff     <= '0;
               div_cnt_ff <= DIV_LAST;
               state_ff   <= ST_DIV;
            end
            ST_DIV: begin
               quo_ff <= quo_in;
               rem_ff <= trial_ge ? trial_diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
               if (div_cnt_ff == '0) begin
                  state_ff <= ST_EMIT;
               end else begin
                  div_cnt_ff <= div_cnt_ff - 1'b1;
               end
            end
            ST_EMIT: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= STATUS_FREQUENCY;
                  rsp_freq_ff   <= freq_sat;
                  rsp_edge_ff   <= edge_wide[EDGE_OUT_BITS-1:0];
                  rsp_count_ff  <= count_wide[COUNT_OUT_BITS-1:0];
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
